[rtl/core/rcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared widths, register indexes and constants of the rms current meter.
// ----------------------------------------------------------------------------
package rcm_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int COUNT_BITS  = 16;

   localparam int OFFSET_BITS = 10;
   localparam int WINDOW_BITS = 16;
   localparam int GAIN_BITS   = 16;
   localparam int DEADBAND_BITS = 16;
   localparam int VOLTS_BITS  = 8;
   localparam int Q_FRAC_BITS = 16;

   localparam int MAG_BITS  = (SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS;
   localparam int SQ_BITS   = 2 * MAG_BITS;
   localparam int SUM_BITS  = SQ_BITS + COUNT_BITS + 1;
   localparam int DVD_BITS  = SUM_BITS + Q_FRAC_BITS;
   localparam int MEAN_BITS = SQ_BITS + Q_FRAC_BITS;
   localparam int RMS_BITS  = MEAN_BITS / 2;
   localparam int CMP_BITS  = (COUNT_BITS > WINDOW_BITS) ? COUNT_BITS : WINDOW_BITS;

   localparam int RMS_OUT_BITS = 18;
   localparam int CUR_BITS     = 16;
   localparam int PWR_BITS     = 24;
   localparam int RMS_WIDE_BITS = (RMS_BITS > RMS_OUT_BITS) ? RMS_BITS : RMS_OUT_BITS;

   localparam int MUL_A_BITS = RMS_BITS;
   localparam int MUL_B_BITS = (MAG_BITS > GAIN_BITS) ? MAG_BITS : GAIN_BITS;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
   localparam int CUR_WIDE_BITS = MUL_P_BITS + 1 - Q_FRAC_BITS;

   localparam int MUL_CNT_BITS  = $clog2(MUL_B_BITS);
   localparam int DIV_CNT_BITS  = $clog2(DVD_BITS);
   localparam int SQRT_CNT_BITS = $clog2(RMS_BITS);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LEN  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MA_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEADBAND    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_VOLTS  = 3'd4;

   localparam logic [WINDOW_BITS-1:0]   RST_WINDOW_LEN  = 16'd10000;
   localparam logic [OFFSET_BITS-1:0]   RST_ZERO_OFFSET = 10'd510;
   localparam logic [GAIN_BITS-1:0]     RST_MA_GAIN     = 16'd18939;
   localparam logic [DEADBAND_BITS-1:0] RST_DEADBAND    = 16'd95;
   localparam logic [VOLTS_BITS-1:0]    RST_LINE_VOLTS  = 8'd220;

   localparam logic [MUL_P_BITS:0]    ROUND_HALF = (MUL_P_BITS + 1)'(32768);
   localparam logic [CUR_WIDE_BITS-1:0] CUR_MAX  = CUR_WIDE_BITS'(65535);

endpackage

[rtl/core/rcm_ser_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_ser_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rcm_ser_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rcm_pkg::MUL_A_BITS-1:0] op_a,
   input  logic [rcm_pkg::MUL_B_BITS-1:0] op_b,
   output logic                           done,
   output logic [rcm_pkg::MUL_P_BITS-1:0] product
);
   import rcm_pkg::*;

   localparam logic [MUL_CNT_BITS-1:0] LAST = MUL_CNT_BITS'(MUL_B_BITS - 1);

   logic [MUL_A_BITS-1:0]   a_ff, a_in;
   logic [MUL_P_BITS-1:0]   p_ff, p_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MUL_A_BITS:0]     part_sum;

   assign part_sum = {1'b0, p_ff[MUL_P_BITS-1:MUL_B_BITS]}
                   + {1'b0, (p_ff[0] ? a_ff : '0)};

   always_comb begin
      a_in    = a_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         p_in    = {{MUL_A_BITS{1'b0}}, op_b};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {part_sum, p_ff[MUL_B_BITS-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

[rtl/core/rcm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_div
// Restoring divider, one quotient bit per cycle: sum * 2^16 / count.
// ----------------------------------------------------------------------------
module rcm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rcm_pkg::SUM_BITS-1:0]  dividend,
   input  logic [rcm_pkg::COUNT_BITS-1:0] divisor,
   output logic                          done,
   output logic [rcm_pkg::MEAN_BITS-1:0] quotient
);
   import rcm_pkg::*;

   localparam logic [DIV_CNT_BITS-1:0] LAST = DIV_CNT_BITS'(DVD_BITS - 1);

   logic [DVD_BITS-1:0]     dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   den_ff, den_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [COUNT_BITS:0]     shifted;
   logic [COUNT_BITS:0]     diff;
   logic                    fits;

   assign shifted = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = {dividend, {Q_FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_BITS-2:0], fits};
         rem_in = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff[MEAN_BITS-1:0];

endmodule

[rtl/core/rcm_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_sqrt
// Digit-by-digit floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rcm_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rcm_pkg::MEAN_BITS-1:0] radicand,
   output logic                          done,
   output logic [rcm_pkg::RMS_BITS-1:0]  root
);
   import rcm_pkg::*;

   localparam logic [SQRT_CNT_BITS-1:0] LAST = SQRT_CNT_BITS'(RMS_BITS - 1);

   logic [MEAN_BITS-1:0]     val_ff, val_in;
   logic [RMS_BITS:0]        rem_ff, rem_in;
   logic [RMS_BITS-1:0]      root_ff, root_in;
   logic [SQRT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [RMS_BITS+2:0]      shifted;
   logic [RMS_BITS+2:0]      trial;
   logic [RMS_BITS+2:0]      diff;
   logic                     fits;

   assign shifted = {rem_ff, val_ff[MEAN_BITS-1:MEAN_BITS-2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign fits    = shifted >= trial;
   assign diff    = shifted - trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[MEAN_BITS-3:0], 2'b00};
         rem_in  = fits ? diff[RMS_BITS:0] : shifted[RMS_BITS:0];
         root_in = {root_ff[RMS_BITS-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/core/rms_current_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_current_meter
// True rms current and power over a window of converter samples.
// ----------------------------------------------------------------------------
// Usage: each item on req_ (valid/ready) is one raw sample. The offset is
// removed, the magnitude squared and added to a running sum. When the count
// reaches window_len (zero acts as one) or the counter is full, one item on
// rsp_ carries rms_code (Q.8 counts), current_ma and power_mw; other samples
// give no item. Registers are written on csr_ with csr_we, no wait.
// A sample is not taken while the bit-serial squarer with its 16 steps works:
// req_ready drops at the accepting edge and returns once the square is added,
// unless the window closes. A window-closing sample keeps req_ready low until
// the result item is valid: after the square come the restoring divider (53
// steps), the square root (18 steps), the serial multiplier twice for gain and
// power (16 steps each) and the start, scale and load states.
// The result sits in an output register, so samples are taken while it waits;
// only the next window close stalls until rsp_ready takes the pending item.
// Reset restores the default registers, clears the sum and the count and
// drops any pending result.
// ----------------------------------------------------------------------------
module rms_current_meter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rcm_pkg::SAMPLE_BITS-1:0]    req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rcm_pkg::RMS_OUT_BITS-1:0]   rsp_rms_code,
   output logic [rcm_pkg::CUR_BITS-1:0]       rsp_current_ma,
   output logic [rcm_pkg::PWR_BITS-1:0]       rsp_power_mw,
   input  logic                               csr_we,
   input  logic [rcm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rcm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rcm_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SQ_GO     = 4'd1;
   localparam logic [3:0] S_SQ_WAIT   = 4'd2;
   localparam logic [3:0] S_DIV_GO    = 4'd3;
   localparam logic [3:0] S_DIV_WAIT  = 4'd4;
   localparam logic [3:0] S_SQRT_GO   = 4'd5;
   localparam logic [3:0] S_SQRT_WAIT = 4'd6;
   localparam logic [3:0] S_GAIN_GO   = 4'd7;
   localparam logic [3:0] S_GAIN_WAIT = 4'd8;
   localparam logic [3:0] S_SCALE     = 4'd9;
   localparam logic [3:0] S_PWR_GO    = 4'd10;
   localparam logic [3:0] S_PWR_WAIT  = 4'd11;
   localparam logic [3:0] S_LOAD      = 4'd12;

   logic [3:0]               state_ff, state_in;
   logic [WINDOW_BITS-1:0]   window_len_ff;
   logic [OFFSET_BITS-1:0]   zero_offset_ff;
   logic [GAIN_BITS-1:0]     ma_gain_ff;
   logic [DEADBAND_BITS-1:0] deadband_ff;
   logic [VOLTS_BITS-1:0]    line_volts_ff;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [MAG_BITS-1:0]      mag_ff, mag_in;
   logic [RMS_BITS-1:0]      rms_ff, rms_in;
   logic [CUR_BITS-1:0]      cur_ff, cur_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RMS_OUT_BITS-1:0]  rsp_rms_ff, rsp_rms_in;
   logic [CUR_BITS-1:0]      rsp_cur_ff, rsp_cur_in;
   logic [PWR_BITS-1:0]      rsp_pwr_ff, rsp_pwr_in;

   logic                     req_acc;
   logic [MAG_BITS-1:0]      s_ext;
   logic [MAG_BITS-1:0]      off_ext;
   logic [COUNT_BITS-1:0]    cnt_next;
   logic [WINDOW_BITS-1:0]   target;
   logic                     win_end;
   logic                     out_free;
   logic [MUL_P_BITS:0]      rnd;
   logic [CUR_WIDE_BITS-1:0] cur_wide;
   logic [CUR_BITS-1:0]      cur_sat;
   logic [RMS_WIDE_BITS-1:0] rms_wide;

   logic                     mul_start, mul_done;
   logic [MUL_A_BITS-1:0]    mul_a;
   logic [MUL_B_BITS-1:0]    mul_b;
   logic [MUL_P_BITS-1:0]    mul_prod;
   logic                     div_start, div_done;
   logic [MEAN_BITS-1:0]     div_quot;
   logic                     sqrt_start, sqrt_done;
   logic [RMS_BITS-1:0]      sqrt_root;

   rcm_ser_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   rcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   rcm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quot),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign s_ext     = MAG_BITS'(req_sample);
   assign off_ext   = MAG_BITS'(zero_offset_ff);
   assign cnt_next  = cnt_ff + 1'b1;
   assign target    = (window_len_ff == '0) ? WINDOW_BITS'(1) : window_len_ff;
   assign win_end   = (CMP_BITS'(cnt_next) >= CMP_BITS'(target)) || (&cnt_next);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rnd      = {1'b0, mul_prod} + ROUND_HALF;
   assign cur_wide = rnd[MUL_P_BITS:Q_FRAC_BITS];
   assign cur_sat  = (cur_wide > CUR_MAX) ? '1 : cur_wide[CUR_BITS-1:0];
   assign rms_wide = RMS_WIDE_BITS'(rms_ff);

   assign mul_start  = (state_ff == S_SQ_GO) || (state_ff == S_GAIN_GO)
                    || (state_ff == S_PWR_GO);
   assign div_start  = (state_ff == S_DIV_GO);
   assign sqrt_start = (state_ff == S_SQRT_GO);

   always_comb begin
      case (state_ff)
         S_SQ_GO: begin
            mul_a = MUL_A_BITS'(mag_ff);
            mul_b = MUL_B_BITS'(mag_ff);
         end
         S_GAIN_GO: begin
            mul_a = rms_ff;
            mul_b = MUL_B_BITS'(ma_gain_ff);
         end
         S_PWR_GO: begin
            mul_a = MUL_A_BITS'(cur_ff);
            mul_b = MUL_B_BITS'(line_volts_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      rms_in       = rms_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_rms_in   = rsp_rms_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_pwr_in   = rsp_pwr_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               mag_in   = (s_ext >= off_ext) ? s_ext - off_ext : off_ext - s_ext;
               state_in = S_SQ_GO;
            end
         end
         S_SQ_GO: begin
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (mul_done) begin
               sum_in   = sum_ff + SUM_BITS'(mul_prod[SQ_BITS-1:0]);
               cnt_in   = cnt_next;
               state_in = win_end ? S_DIV_GO : S_IDLE;
            end
         end
         S_DIV_GO: begin
            sum_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               state_in = S_SQRT_GO;
            end
         end
         S_SQRT_GO: begin
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (sqrt_done) begin
               rms_in   = sqrt_root;
               state_in = S_GAIN_GO;
            end
         end
         S_GAIN_GO: begin
            state_in = S_GAIN_WAIT;
         end
         S_GAIN_WAIT: begin
            if (mul_done) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cur_in   = (cur_sat <= deadband_ff) ? '0 : cur_sat;
            state_in = S_PWR_GO;
         end
         S_PWR_GO: begin
            state_in = S_PWR_WAIT;
         end
         S_PWR_WAIT: begin
            if (mul_done) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = rms_wide[RMS_OUT_BITS-1:0];
               rsp_cur_in   = cur_ff;
               rsp_pwr_in   = mul_prod[PWR_BITS-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         sum_ff         <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         window_len_ff  <= RST_WINDOW_LEN;
         zero_offset_ff <= RST_ZERO_OFFSET;
         ma_gain_ff     <= RST_MA_GAIN;
         deadband_ff    <= RST_DEADBAND;
         line_volts_ff  <= RST_LINE_VOLTS;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_WINDOW_LEN:  window_len_ff  <= csr_wdata[WINDOW_BITS-1:0];
               REG_ZERO_OFFSET: zero_offset_ff <= csr_wdata[OFFSET_BITS-1:0];
               REG_MA_GAIN:     ma_gain_ff     <= csr_wdata[GAIN_BITS-1:0];
               REG_DEADBAND:    deadband_ff    <= csr_wdata[DEADBAND_BITS-1:0];
               REG_LINE_VOLTS:  line_volts_ff  <= csr_wdata[VOLTS_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      rms_ff     <= rms_in;
      cur_ff     <= cur_in;
      rsp_rms_ff <= rsp_rms_in;
      rsp_cur_ff <= rsp_cur_in;
      rsp_pwr_ff <= rsp_pwr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rms_code   = rsp_rms_ff;
   assign rsp_current_ma = rsp_cur_ff;
   assign rsp_power_mw   = rsp_pwr_ff;

endmodule

[rtl/core/rcm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level assertions for the rms current meter, bound to the top level.
// ----------------------------------------------------------------------------
module rcm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rcm_pkg::RMS_OUT_BITS-1:0]   rsp_rms_code,
   input logic [rcm_pkg::CUR_BITS-1:0]       rsp_current_ma,
   input logic [rcm_pkg::PWR_BITS-1:0]       rsp_power_mw
);
   import rcm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rms_code)
         && $stable(rsp_current_ma) && $stable(rsp_power_mw))
      else $error("stalled result item changed");

   a_reset_drop: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item survived reset");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while squaring");

   a_zero_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_current_ma == '0) |-> (rsp_power_mw == '0))
      else $error("power without current");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item appeared while idle");

endmodule

bind rms_current_meter rcm_checker u_rcm_checker (.*);

[tb/tb_rms_current_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rms_current_meter
// Self-checking bench for the windowed true rms current and power meter.
// ----------------------------------------------------------------------------
// Raw samples go in on req_ from a queue that the stimulus block fills. A
// shadow of the registers and of the running sum and count predicts every
// window close: mean square in Q16, floor root, rounded gain with saturation
// and deadband, then power. Readings on rsp_ are compared field by field with
// the oldest prediction. Directed windows cover the field extremes, a zero
// window, the deadband edge, half-up rounding, masked and ignored register
// writes and a window shortened after a long one. Random phases follow under
// three idling mixes, with one long receiver stall and a sender pause in each.
// ----------------------------------------------------------------------------
module tb_rms_current_meter;
   import rcm_pkg::*;

   localparam int SETTLE_CYCLES = 200;
   localparam int LONG_STALL    = 2500;
   localparam int QUIET_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 50;

   typedef struct packed {
      logic [RMS_OUT_BITS-1:0] rms_code;
      logic [CUR_BITS-1:0]     current_ma;
      logic [PWR_BITS-1:0]     power_mw;
   } meter_reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [RMS_OUT_BITS-1:0]   rsp_rms_code;
   logic [CUR_BITS-1:0]       rsp_current_ma;
   logic [PWR_BITS-1:0]       rsp_power_mw;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic [WINDOW_BITS-1:0]   cfg_window;
   logic [OFFSET_BITS-1:0]   cfg_offset;
   logic [GAIN_BITS-1:0]     cfg_gain;
   logic [DEADBAND_BITS-1:0] cfg_deadband;
   logic [VOLTS_BITS-1:0]    cfg_volts;
   longint unsigned          sq_total;
   logic [COUNT_BITS-1:0]    samples_in_window;

   logic [SAMPLE_BITS-1:0] samples_pending[$];
   meter_reading_type      readings_due[$];
   int unsigned            samples_queued = 0;
   int unsigned            samples_taken = 0;
   int unsigned            send_idle_pct = 0;
   int unsigned            recv_idle_pct = 0;
   int unsigned            error_count = 0;
   int unsigned            quiet_cycles = 0;
   int unsigned            stall_left = 0;
   logic [7:0]             stall_trigger = '0;
   logic [7:0]             stall_seen = '0;

   rms_current_meter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rms_code   (rsp_rms_code),
      .rsp_current_ma (rsp_current_ma),
      .rsp_power_mw   (rsp_power_mw),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      if (error_count < 60) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   task automatic take_sample(input logic [SAMPLE_BITS-1:0] s);
      longint unsigned   mag;
      longint unsigned   target;
      longint unsigned   mean_q16;
      longint unsigned   root;
      longint unsigned   amps;
      longint unsigned   watts;
      meter_reading_type r;
      if (s >= cfg_offset) begin
         mag = longint'(s) - longint'(cfg_offset);
      end else begin
         mag = longint'(cfg_offset) - longint'(s);
      end
      target = (cfg_window == 0) ? 1 : longint'(cfg_window);
      sq_total += mag * mag;
      samples_in_window = samples_in_window + 1'b1;
      if (samples_in_window < target && samples_in_window != '1) begin
         return;
      end
      mean_q16 = (sq_total << 16) / longint'(samples_in_window);
      root = floor_root(mean_q16);
      amps = (root * longint'(cfg_gain) + 64'd32768) >> 16;
      if (amps > 64'd65535) begin
         amps = 64'd65535;
      end
      if (amps <= longint'(cfg_deadband)) begin
         amps = 0;
      end
      watts = amps * longint'(cfg_volts);
      r.rms_code   = root[RMS_OUT_BITS-1:0];
      r.current_ma = amps[CUR_BITS-1:0];
      r.power_mw   = watts[PWR_BITS-1:0];
      readings_due.push_back(r);
      sq_total = 0;
      samples_in_window = '0;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_WINDOW_LEN:  cfg_window   = val[WINDOW_BITS-1:0];
         REG_ZERO_OFFSET: cfg_offset   = val[OFFSET_BITS-1:0];
         REG_MA_GAIN:     cfg_gain     = val[GAIN_BITS-1:0];
         REG_DEADBAND:    cfg_deadband = val[DEADBAND_BITS-1:0];
         REG_LINE_VOLTS:  cfg_volts    = val[VOLTS_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] window,
                            input logic [CSR_DATA_BITS-1:0] offset,
                            input logic [CSR_DATA_BITS-1:0] gain,
                            input logic [CSR_DATA_BITS-1:0] deadband,
                            input logic [CSR_DATA_BITS-1:0] volts);
      write_reg(REG_WINDOW_LEN, window);
      write_reg(REG_ZERO_OFFSET, offset);
      write_reg(REG_MA_GAIN, gain);
      write_reg(REG_DEADBAND, deadband);
      write_reg(REG_LINE_VOLTS, volts);
   endtask

   task automatic queue_sample(input logic [SAMPLE_BITS-1:0] s);
      samples_pending.push_back(s);
      samples_queued++;
   endtask

   task automatic drain_readings();
      while (samples_taken != samples_queued) @(posedge clock);
      while (readings_due.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain_readings();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int v;
      case ($urandom_range(9))
         0: v = 0;
         1: v = 1023;
         2, 3: v = int'(cfg_offset) + int'($urandom_range(16)) - 8;
         default: v = $urandom_range(1023);
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[SAMPLE_BITS-1:0];
   endfunction

   task automatic randomize_settings(input bit short_window);
      logic [CSR_DATA_BITS-1:0] window, offset, gain, deadband, volts;
      case ($urandom_range(19))
         0: window = 0;
         1: window = 1;
         2: window = CSR_DATA_BITS'($urandom_range(20, 60));
         default: window = CSR_DATA_BITS'($urandom_range(2, 8));
      endcase
      if (short_window) window = 2;
      case ($urandom_range(5))
         0: offset = 0;
         1: offset = 1023;
         2: offset = CSR_DATA_BITS'($urandom_range(65535));
         default: offset = CSR_DATA_BITS'($urandom_range(400, 620));
      endcase
      case ($urandom_range(5))
         0: gain = 0;
         1: gain = 65535;
         2: gain = CSR_DATA_BITS'($urandom_range(1, 2000));
         default: gain = CSR_DATA_BITS'($urandom_range(65535));
      endcase
      case ($urandom_range(5))
         0: deadband = 0;
         1: deadband = 65535;
         default: deadband = CSR_DATA_BITS'($urandom_range(4000));
      endcase
      volts = ($urandom_range(3) == 0) ? CSR_DATA_BITS'($urandom_range(65535))
                                       : CSR_DATA_BITS'($urandom_range(255));
      if ($urandom_range(3) == 0) begin
         write_reg(CSR_INDEX_BITS'($urandom_range(5, 7)),
                   CSR_DATA_BITS'($urandom_range(65535)));
      end
      configure(window, offset, gain, deadband, volts);
   endtask

   // sender: hold the item until taken, then offer the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            take_sample(req_sample);
            samples_taken++;
         end
         if (!req_valid || req_ready) begin
            if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid  <= 1'b1;
               req_sample <= samples_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_trigger != stall_seen) begin
         stall_seen <= stall_trigger;
         stall_left <= LONG_STALL;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : reading_check
      meter_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (readings_due.size() == 0) begin
            flag_error($sformatf("unexpected reading rms_code=%0d current_ma=%0d",
                                 rsp_rms_code, rsp_current_ma));
         end else begin
            want = readings_due.pop_front();
            if (rsp_rms_code !== want.rms_code)
               flag_error($sformatf("rms_code %0d, want %0d", rsp_rms_code, want.rms_code));
            if (rsp_current_ma !== want.current_ma)
               flag_error($sformatf("current_ma %0d, want %0d",
                                    rsp_current_ma, want.current_ma));
            if (rsp_power_mw !== want.power_mw)
               flag_error($sformatf("power_mw %0d, want %0d", rsp_power_mw, want.power_mw));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_window        = RST_WINDOW_LEN;
      cfg_offset        = RST_ZERO_OFFSET;
      cfg_gain          = RST_MA_GAIN;
      cfg_deadband      = RST_DEADBAND;
      cfg_volts         = RST_LINE_VOLTS;
      sq_total          = 0;
      samples_in_window = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 49;

      // zero window closes on every sample, full scale saturates
      configure(0, 0, 65535, 0, 255);
      queue_sample(1023);
      queue_sample(0);
      queue_sample(1);
      queue_sample(512);
      settle();

      // saturated current still falls inside the widest deadband
      configure(1, 1023, 65535, 65535, 0);
      queue_sample(0);
      queue_sample(1023);
      settle();

      // half-up rounding
      configure(2, 510, 32768, 5, 100);
      queue_sample(511);
      queue_sample(510);
      queue_sample(520);
      queue_sample(500);
      queue_sample(515);
      queue_sample(515);
      settle();

      // deadband edge: equal reads zero, one above passes
      configure(1, 510, 256, 5, 200);
      queue_sample(515);
      queue_sample(516);
      queue_sample(504);
      settle();

      // ignored indexes, masked data, zero gain
      write_reg(CSR_INDEX_BITS'(5), 16'h1234);
      write_reg(CSR_INDEX_BITS'(6), 16'hFFFF);
      write_reg(CSR_INDEX_BITS'(7), 16'h0001);
      configure(3, 16'hFFFF, 0, 0, 16'h01FF);
      queue_sample(0);
      queue_sample(100);
      queue_sample(1023);
      settle();

      // longest window, then shorten it mid-window
      configure(65535, 510, 18939, 95, 220);
      repeat (5) queue_sample(SAMPLE_BITS'($urandom_range(1023)));
      settle();
      write_reg(REG_WINDOW_LEN, 2);
      queue_sample(SAMPLE_BITS'($urandom_range(1023)));
      queue_sample(SAMPLE_BITS'($urandom_range(1023)));
      settle();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 37; recv_idle_pct = 49; end
            1: begin send_idle_pct = 49; recv_idle_pct = 37; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int ph = 0; ph < 9; ph++) begin
            randomize_settings(mode == 0 && ph == 0);
            if (mode == 0 && ph == 0) begin
               // back up the output while the sender keeps offering
               repeat (PHASE_ITEMS) queue_sample(pick_sample());
               @(posedge clock);
               stall_trigger <= stall_trigger + 1'b1;
            end else if (ph == 4) begin
               // pause the sender until every reading is back
               repeat (PHASE_ITEMS / 2) queue_sample(pick_sample());
               drain_readings();
               repeat (PHASE_ITEMS / 2) queue_sample(pick_sample());
            end else begin
               repeat (PHASE_ITEMS) queue_sample(pick_sample());
            end
            settle();
         end
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[rms_current_meter.f]
rtl/core/rcm_pkg.sv
rtl/core/rcm_ser_mul.sv
rtl/core/rcm_div.sv
rtl/core/rcm_sqrt.sv
rtl/core/rms_current_meter.sv
rtl/core/rcm_checker.sv
tb/tb_rms_current_meter.sv
